// File: rtl/assert_macros.svh
// Assertion macros shared by the line rasterizer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check a property on every rising edge outside reset.
`define ASSERT_DIS(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Check that one condition implies another in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`else
`define ASSERT_DIS(label, clk, rst, prop, msg)
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg)
`endif
`endif

// File: rtl/dlrw_pkg.sv
// Shared types and constants of the wrapping line rasterizer.
`timescale 1ns / 1ps
package dlrw_pkg;
  localparam int CFG_W = 13;
  localparam int PIX_W = 12;
  localparam logic [CFG_W-1:0] WIDTH_RESET = 13'd1024;
  localparam logic [CFG_W-1:0] WIDTH_MAX   = 13'd4096;

  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_STEP = 1'b1;

  typedef enum logic [1:0] {
    OP_DIVX = 2'd0,
    OP_DIVY = 2'd1,
    OP_MOD  = 2'd2
  } div_op_t;

  typedef struct packed {
    logic    load;
    logic    step;
    logic    div_start;
    div_op_t div_op;
  } ctrl_cmd_t;

  typedef struct packed {
    logic line_active;
    logic steps_one;
    logic div_busy;
    logic div_done;
    logic out_room;
  } dp_status_t;

  typedef struct packed {
    logic [PIX_W-1:0] x;
    logic [PIX_W-1:0] y;
    logic             last;
  } pix_t;
endpackage

// File: rtl/dlrw_ifs.sv
// Request and pixel channel interfaces.
`timescale 1ns / 1ps
interface dlrw_req_if #(parameter int COORD_BITS = 12) ();
  logic                  valid;
  logic                  ready;
  logic                  req_type;
  logic [COORD_BITS-1:0] start_x;
  logic [COORD_BITS-1:0] start_y;
  logic [COORD_BITS-1:0] end_x;
  logic [COORD_BITS-1:0] end_y;

  modport source (output valid, req_type, start_x, start_y, end_x, end_y, input ready);
  modport sink   (input valid, req_type, start_x, start_y, end_x, end_y, output ready);
endinterface

interface dlrw_pix_if ();
  import dlrw_pkg::*;
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_x;
  logic [PIX_W-1:0] pixel_y;
  logic             last_pixel;

  modport source (output valid, pixel_x, pixel_y, last_pixel, input ready);
  modport sink   (input valid, pixel_x, pixel_y, last_pixel, output ready);
endinterface

// File: rtl/dlrw_div.sv
// Iterative restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module dlrw_div #(
  parameter int NW = 30,
  parameter int VW = 13
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic          busy,
  output logic          done,
  output logic [NW-1:0] quot,
  output logic [VW-1:0] rem
);
  localparam int CNT_W = $clog2(NW + 1);

  logic [NW-1:0]    q;
  logic [VW:0]      r;
  logic [VW-1:0]    d;
  logic [CNT_W-1:0] cnt;
  logic [VW:0]      r_sh;
  logic [VW:0]      r_sub;
  logic             take;

  assign r_sh  = {r[VW-1:0], q[NW-1]};
  assign r_sub = r_sh - {1'b0, d};
  assign take  = (r_sh >= {1'b0, d});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(NW);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q <= dividend;
      r <= '0;
      d <= divisor;
    end else if (busy) begin
      q <= {q[NW-2:0], take};
      r <= take ? r_sub : r_sh;
    end
  end

  assign quot = q;
  assign rem  = r[VW-1:0];
endmodule

// File: rtl/dlrw_dp.sv
// Datapath: span choice, fixed-point position, column wrap and output buffer.
`timescale 1ns / 1ps
module dlrw_dp #(
  parameter int COORD_BITS = 12,
  parameter int FRAC_BITS  = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  dlrw_pkg::ctrl_cmd_t          cmd,
  output dlrw_pkg::dp_status_t         status,
  input  logic [COORD_BITS-1:0]        start_x,
  input  logic [COORD_BITS-1:0]        start_y,
  input  logic [COORD_BITS-1:0]        end_x,
  input  logic [COORD_BITS-1:0]        end_y,
  input  logic                         cfg_we,
  input  logic [dlrw_pkg::CFG_W-1:0]   cfg_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output dlrw_pkg::pix_t               out_pix
);
  import dlrw_pkg::*;

  localparam int C  = COORD_BITS;
  localparam int F  = FRAC_BITS;
  localparam int M  = (C > CFG_W) ? C : CFG_W;
  localparam int DW = M + 2;
  localparam int IW = DW;
  localparam int PW = IW + F;
  localparam int SW = F + 2;
  localparam int TW = CFG_W + 2;
  localparam int NW_FIX = C + F + 2;
  localparam int NW_MOD = M + 1;
  localparam int NW = (NW_FIX > NW_MOD) ? NW_FIX : NW_MOD;
  localparam int VW = (C + 1 > CFG_W) ? C + 1 : CFG_W;

  function automatic logic [DW-1:0] abs_d(input logic signed [DW-1:0] v);
    abs_d = v[DW-1] ? DW'(-v) : DW'(v);
  endfunction

  // Round half away from zero to whole pixels.
  function automatic logic signed [IW-1:0] round_pos(input logic signed [PW-1:0] v);
    logic [PW-1:0] mag;
    logic [PW-1:0] sum;
    logic [IW-1:0] r;
    mag = v[PW-1] ? PW'(-v) : PW'(v);
    sum = mag + (PW'(1) << (F - 1));
    r   = sum[PW-1:F];
    round_pos = v[PW-1] ? signed'(-r) : signed'(r);
  endfunction

  function automatic logic signed [TW-1:0] wrap_once(input logic signed [TW-1:0] t,
                                                     input logic signed [TW-1:0] w);
    if (t < 0) begin
      wrap_once = t + w;
    end else if (t >= w) begin
      wrap_once = t - w;
    end else begin
      wrap_once = t;
    end
  endfunction

  // Canvas width register and its clamped value.
  logic [CFG_W-1:0] width_reg;
  logic [CFG_W-1:0] weff;

  always_ff @(posedge clk) begin
    if (rst) begin
      width_reg <= WIDTH_RESET;
    end else if (cfg_we) begin
      width_reg <= cfg_data;
    end
  end

  assign weff = (width_reg == '0) ? CFG_W'(1) :
                (width_reg > WIDTH_MAX) ? WIDTH_MAX : width_reg;

  // Span selection on load.
  logic signed [DW-1:0] x1s, y1s, x2s, y2s, ws;
  logic signed [DW-1:0] dx_d, dy_d, wdx, wx1, dx_sel, x1_sel;
  logic [DW-1:0]        adx, ady, smax;

  always_comb begin
    x1s  = signed'(DW'(start_x));
    y1s  = signed'(DW'(start_y));
    x2s  = signed'(DW'(end_x));
    y2s  = signed'(DW'(end_y));
    ws   = signed'(DW'(weff));
    dx_d = x2s - x1s;
    dy_d = y2s - y1s;
    if (x1s <= x2s) begin
      wx1 = x1s;
      wdx = x2s - ws - x1s;
    end else begin
      wx1 = x1s - ws;
      wdx = x2s - wx1;
    end
    if (abs_d(wdx) <= abs_d(dx_d)) begin
      dx_sel = wdx;
      x1_sel = wx1;
    end else begin
      dx_sel = dx_d;
      x1_sel = x1s;
    end
    adx  = abs_d(dx_sel);
    ady  = abs_d(dy_d);
    smax = (adx > ady) ? adx : ady;
  end

  // Line state.
  logic signed [PW-1:0] pos_x, pos_y;
  logic signed [IW-1:0] rx, ry;
  logic [CFG_W-1:0]     mx;
  logic signed [SW-1:0] step_x, step_y;
  logic [C-1:0]         steps_left;
  logic [C-1:0]         s_r;
  logic [C-1:0]         sx_mag, sy_mag;
  logic                 sx_neg, sy_neg;
  logic                 line_active;

  assign line_active = (steps_left != '0);

  // Shared divider: step increments and the column reduction.
  logic          div_busy, div_done;
  logic [NW-1:0] div_dividend, div_quot;
  logic [VW-1:0] div_divisor, div_rem;
  div_op_t       cur_op;
  logic [C-1:0]  num_mag;

  always_comb begin
    num_mag = (cmd.div_op == OP_DIVY) ? sy_mag : sx_mag;
    unique case (cmd.div_op)
      OP_DIVX, OP_DIVY: begin
        div_dividend = (NW'(num_mag) << (F + 1)) + NW'(s_r);
        div_divisor  = VW'(s_r) << 1;
      end
      OP_MOD: begin
        div_dividend = NW'(rx[IW-1] ? IW'(-rx) : IW'(rx));
        div_divisor  = VW'(weff);
      end
      default: begin
        div_dividend = '0;
        div_divisor  = VW'(1);
      end
    endcase
  end

  dlrw_div #(.NW(NW), .VW(VW)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .done     (div_done),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  logic signed [SW-1:0] q_fix;
  logic [CFG_W-1:0]     r_mod;

  assign q_fix = signed'({1'b0, div_quot[F:0]});
  assign r_mod = div_rem[CFG_W-1:0];

  // Per-pixel advance.
  logic                 push;
  logic signed [PW-1:0] pos_x_n, pos_y_n;
  logic signed [IW-1:0] rx_n, ry_n, d_x;
  logic signed [TW-1:0] t0, t1, t2, w_t;
  pix_t                 pix_new;

  assign push = cmd.step && line_active;

  always_comb begin
    pos_x_n = pos_x + {{(PW-SW){step_x[SW-1]}}, step_x};
    pos_y_n = pos_y + {{(PW-SW){step_y[SW-1]}}, step_y};
    rx_n    = round_pos(pos_x_n);
    ry_n    = round_pos(pos_y_n);
    d_x     = rx_n - rx;
    w_t     = signed'(TW'(weff));
    t0      = signed'(TW'(mx)) + signed'(d_x[TW-1:0]);
    t1      = wrap_once(t0, w_t);
    t2      = wrap_once(t1, w_t);
    pix_new.x    = mx[PIX_W-1:0];
    pix_new.y    = ry[PIX_W-1:0];
    pix_new.last = (steps_left == C'(1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      steps_left <= '0;
    end else if (cmd.load) begin
      steps_left <= smax[C-1:0];
    end else if (push) begin
      steps_left <= steps_left - C'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      s_r    <= smax[C-1:0];
      sx_neg <= dx_sel[DW-1];
      sy_neg <= dy_d[DW-1];
      sx_mag <= adx[C-1:0];
      sy_mag <= ady[C-1:0];
      pos_x  <= {x1_sel, {F{1'b0}}};
      pos_y  <= {y1s, {F{1'b0}}};
      rx     <= x1_sel;
      ry     <= y1s;
    end else if (push) begin
      pos_x <= pos_x_n;
      pos_y <= pos_y_n;
      rx    <= rx_n;
      ry    <= ry_n;
      mx    <= t2[CFG_W-1:0];
    end
    if (cmd.div_start) begin
      cur_op <= cmd.div_op;
    end
    if (div_done) begin
      unique case (cur_op)
        OP_DIVX: step_x <= sx_neg ? -q_fix : q_fix;
        OP_DIVY: step_y <= sy_neg ? -q_fix : q_fix;
        OP_MOD:  mx     <= (rx[IW-1] && r_mod != '0) ? weff - r_mod : r_mod;
        default: ;
      endcase
    end
  end

  // Two-entry output buffer.
  logic [1:0] cnt;
  logic       pop;
  pix_t       ent0, ent1;

  assign pop = (cnt != 2'd0) && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else if (push && !pop) begin
      cnt <= cnt + 2'd1;
    end else if (pop && !push) begin
      cnt <= cnt - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (cnt == 2'd2) begin
        ent0 <= ent1;
      end else if (push) begin
        ent0 <= pix_new;
      end
    end else if (push) begin
      if (cnt == 2'd0) begin
        ent0 <= pix_new;
      end else begin
        ent1 <= pix_new;
      end
    end
  end

  assign out_valid = (cnt != 2'd0);
  assign out_pix   = ent0;

  assign status.line_active = line_active;
  assign status.steps_one   = (steps_left == C'(1));
  assign status.div_busy    = div_busy;
  assign status.div_done    = div_done;
  assign status.out_room    = (cnt != 2'd2);
endmodule

// File: rtl/dlrw_ctrl.sv
// Controller: request acceptance and divider sequencing.
`timescale 1ns / 1ps
module dlrw_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 req_type,
  output logic                 in_ready,
  input  logic                 cfg_we,
  input  dlrw_pkg::dp_status_t status,
  output dlrw_pkg::ctrl_cmd_t  cmd
);
  import dlrw_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SETUP = 5'b00010,
    S_DIVX  = 5'b00100,
    S_DIVY  = 5'b01000,
    S_REMOD = 5'b10000
  } state_t;

  state_t state, state_next;
  logic   pending, pending_next;

  always_comb begin
    state_next   = state;
    pending_next = pending | cfg_we;
    cmd          = '0;
    in_ready     = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (pending) begin
          // width changed: redo the column reduction before the next pixel
          if (status.line_active) begin
            cmd.div_start = 1'b1;
            cmd.div_op    = OP_MOD;
            state_next    = S_REMOD;
          end else begin
            pending_next = cfg_we;
          end
        end else begin
          in_ready = status.out_room;
          if (in_valid && status.out_room) begin
            if (req_type == REQ_LOAD) begin
              cmd.load   = 1'b1;
              state_next = S_SETUP;
            end else begin
              cmd.step = 1'b1;
            end
          end
        end
      end
      S_SETUP: begin
        if (status.line_active) begin
          cmd.div_start = 1'b1;
          cmd.div_op    = OP_DIVX;
          state_next    = S_DIVX;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_DIVX: begin
        if (status.div_done) begin
          cmd.div_start = 1'b1;
          cmd.div_op    = OP_DIVY;
          state_next    = S_DIVY;
        end
      end
      S_DIVY: begin
        if (status.div_done) begin
          cmd.div_start = 1'b1;
          cmd.div_op    = OP_MOD;
          state_next    = S_REMOD;
        end
      end
      S_REMOD: begin
        if (status.div_done) begin
          pending_next = cfg_we;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      pending <= 1'b0;
    end else begin
      state   <= state_next;
      pending <= pending_next;
    end
  end
endmodule

// File: rtl/dda_line_rasterizer_wrap.sv
// Top level of the horizontally wrapping DDA line rasterizer.
//
//  channel | dir | transaction                       | payload
//  --------+-----+-----------------------------------+------------------------------------
//  req     | in  | load a line or ask for one pixel  | req_type, start_x/y, end_x/y
//  pix     | out | one rasterized pixel              | pixel_x, pixel_y, last_pixel
//  cfg     | in  | write canvas width (no read-back) | cfg_we, cfg_data
//
// A step transaction yields one pixel into a two-entry output buffer while a line is active;
// steps can follow every cycle while the buffer has room and no load or width write is pending.
// A load runs the shared one-bit-per-cycle divider for step x, step y and the column modulo
// in turn, unless the loaded line has no steps.
// A width write holds req while the divider redoes the column modulo with a line active,
// and only while its pending flag clears with no line active.
// Reset is synchronous: width returns to 1024, no line is active, the buffer empties.
// A stalled pix channel holds its data; req stalls while the buffer is full, during a
// load and after a width write.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module dda_line_rasterizer_wrap #(
  parameter int COORD_BITS = 12,
  parameter int FRAC_BITS  = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  dlrw_req_if.sink                   req,
  dlrw_pix_if.source                 pix,
  input  logic                       cfg_we,
  input  logic [dlrw_pkg::CFG_W-1:0] cfg_data
);
  import dlrw_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;
  pix_t       out_pix;
  logic       out_valid;

  // Sequence loads, steps and divider runs.
  dlrw_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .req_type (req.req_type),
    .in_ready (req.ready),
    .cfg_we   (cfg_we),
    .status   (status),
    .cmd      (cmd)
  );

  // Hold line state, advance the position, buffer the pixels.
  dlrw_dp #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .start_x   (req.start_x),
    .start_y   (req.start_y),
    .end_x     (req.end_x),
    .end_y     (req.end_y),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_ready (pix.ready),
    .out_pix   (out_pix)
  );

  // Drive the pixel channel straight from the head of the buffer.
  assign pix.valid      = out_valid;
  assign pix.pixel_x    = out_pix.x;
  assign pix.pixel_y    = out_pix.y;
  assign pix.last_pixel = out_pix.last;

  `ASSERT_IMPLIES(a_no_restart, clk, rst, cmd.div_start, !status.div_busy, "divider restarted while busy")
  `ASSERT_IMPLIES(a_ready_quiet, clk, rst, req.ready, !status.div_busy, "request ready during a divide")
  `ASSERT_DIS(a_last_ends, clk, rst, (cmd.step && status.line_active && status.steps_one) |=> !status.line_active, "line still active after last pixel")
  `ASSERT_DIS(a_push_shows, clk, rst, (cmd.step && status.line_active) |=> pix.valid, "emitted pixel not presented")
endmodule
